[design/psgfs_pkg.sv]
// shared types, codes and constants of the psg frame sequencer
package psgfs_pkg;

   localparam int LENGTH_WIDTH_DEFAULT = 9;
   localparam int LEN_FIELD_W          = 9;
   localparam int FREQ_W               = 11;
   localparam int VOL_W                = 4;
   localparam int NUM_CHANNELS         = 4;
   localparam int NUM_ENVELOPES        = 3;

   localparam logic [2:0]       STEP_SWEEP_A = 3'd2;
   localparam logic [2:0]       STEP_SWEEP_B = 3'd6;
   localparam logic [2:0]       STEP_ENV     = 3'd7;
   localparam logic [VOL_W-1:0] VOL_MAX      = 4'hF;

   localparam logic [1:0] CH_SQUARE_A = 2'd0;
   localparam logic [1:0] CH_SQUARE_B = 2'd1;
   localparam logic [1:0] CH_WAVE     = 2'd2;
   localparam logic [1:0] CH_NOISE    = 2'd3;

   // channel served by each envelope unit
   localparam logic [1:0] ENV_CHANNEL [NUM_ENVELOPES] = '{CH_SQUARE_A, CH_SQUARE_B, CH_NOISE};

   typedef enum logic [2:0] {
      OP_TICK         = 3'd0,
      OP_LENGTH_LOAD  = 3'd1,
      OP_SWEEP_LOAD   = 3'd2,
      OP_ENV_LOAD     = 3'd3,
      OP_ENABLE_WRITE = 3'd4
   } psgfs_op_type;

   typedef struct packed {
      logic [2:0]             operation;
      logic [1:0]             channel;
      logic                   enable_bit;
      logic [LEN_FIELD_W-1:0] length_value;
      logic [FREQ_W-1:0]      frequency;
      logic [2:0]             sweep_shift;
      logic [2:0]             sweep_period;
      logic                   direction;
      logic [2:0]             envelope_period;
      logic [VOL_W-1:0]       start_volume;
   } psgfs_req_type;

   typedef struct packed {
      logic [NUM_CHANNELS-1:0] channel_enables;
      logic [FREQ_W-1:0]       sweep_frequency;
      logic [VOL_W-1:0]        volume_square_a;
      logic [VOL_W-1:0]        volume_square_b;
      logic [VOL_W-1:0]        volume_noise;
      logic [2:0]              sequencer_position;
   } psgfs_rsp_type;

   // per-request strobes to the units, already qualified by the request being processed
   typedef struct packed {
      logic tick_length;
      logic tick_sweep;
      logic tick_env;
      logic load_length;
      logic load_sweep;
      logic load_env;
      logic write_enable;
   } psgfs_ctrl_type;

endpackage

[design/psg_frame_sequencer.sv]
// top level of the psg frame sequencer: request register, decode, units, result register
//
// usage
//  - req channel: one request per accepted edge (req_valid high, req_stall low);
//    a request is a tick of the 512 Hz frame clock or a load of one unit
//  - rsp channel: exactly one response per request, in request order, carrying
//    channel enables, sweep frequency, three envelope volumes and the step
//    position as they stand after that request
//  - path: the request lands in the input register and from there runs through the
//    length, sweep and envelope logic into the result register
//  - throughput: one request per cycle while the response is not stalled, set by the single pass through the units
//  - a stalled response holds in the result register while the input register
//    still takes one more request; req_stall rises only when both are full
//  - reset (synchronous) clears both registers' valid flags, the step counter,
//    the channel enables and every unit's state; no response is pending after it
module psg_frame_sequencer
   import psgfs_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  psgfs_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output psgfs_rsp_type rsp_data
);

   // input register
   logic          in_valid_ff;
   logic          in_valid_in;
   psgfs_req_type in_ff;

   // result register
   logic          out_valid_ff;
   logic          out_valid_in;
   psgfs_rsp_type out_ff;
   psgfs_rsp_type out_in;

   // block state kept at this level
   logic [2:0]              seq_ff;
   logic [2:0]              seq_in;
   logic [NUM_CHANNELS-1:0] on_ff;
   logic [NUM_CHANNELS-1:0] on_in;

   logic                    out_free;
   logic                    fire;
   psgfs_ctrl_type          ctrl;
   logic [NUM_CHANNELS-1:0] len_expire;
   logic                    sweep_overflow;
   logic [FREQ_W-1:0]       sweep_freq_in;
   logic [VOL_W-1:0]        env_volume_in [NUM_ENVELOPES];
   logic [NUM_ENVELOPES-1:0] env_load;

   // result slot is free when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   // request decode, strobes only while the request is processed
   always_comb begin
      ctrl = '0;
      if (fire) begin
         unique case (psgfs_op_type'(in_ff.operation))
            OP_TICK: begin
               ctrl.tick_length = ~seq_ff[0];
               ctrl.tick_sweep  = (seq_ff == STEP_SWEEP_A) || (seq_ff == STEP_SWEEP_B);
               ctrl.tick_env    = (seq_ff == STEP_ENV);
            end
            OP_LENGTH_LOAD:  ctrl.load_length  = 1'b1;
            OP_SWEEP_LOAD:   ctrl.load_sweep   = 1'b1;
            OP_ENV_LOAD:     ctrl.load_env     = 1'b1;
            OP_ENABLE_WRITE: ctrl.write_enable = 1'b1;
            default: ;  // unused codes leave the state alone
         endcase
      end
   end

   // step counter wraps naturally at eight steps
   assign seq_in = (fire && psgfs_op_type'(in_ff.operation) == OP_TICK) ? seq_ff + 3'd1
                                                                         : seq_ff;

   // channel enables: length expiry and sweep overflow only clear, the write sets or clears
   always_comb begin
      on_in = on_ff & ~len_expire;
      if (sweep_overflow) begin
         on_in[CH_SQUARE_A] = 1'b0;
      end
      if (ctrl.write_enable) begin
         on_in[in_ff.channel] = in_ff.enable_bit;
      end
   end

   psgfs_length #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
   ) u_length (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .channel      (in_ff.channel),
      .enable_bit   (in_ff.enable_bit),
      .length_value (in_ff.length_value),
      .expire       (len_expire)
   );

   psgfs_sweep u_sweep (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .frequency    (in_ff.frequency),
      .sweep_shift  (in_ff.sweep_shift),
      .sweep_period (in_ff.sweep_period),
      .direction    (in_ff.direction),
      .freq_in      (sweep_freq_in),
      .overflow     (sweep_overflow)
   );

   // the wave channel has no envelope, its loads match no unit
   for (genvar e = 0; e < NUM_ENVELOPES; e++) begin : g_env
      assign env_load[e] = ctrl.load_env && (in_ff.channel == ENV_CHANNEL[e]);

      psgfs_envelope u_envelope (
         .clock           (clock),
         .reset           (reset),
         .tick            (ctrl.tick_env),
         .load            (env_load[e]),
         .direction       (in_ff.direction),
         .envelope_period (in_ff.envelope_period),
         .start_volume    (in_ff.start_volume),
         .volume_in       (env_volume_in[e])
      );
   end

   // response shows the state after this request
   always_comb begin
      out_in.channel_enables    = on_in;
      out_in.sweep_frequency    = sweep_freq_in;
      out_in.volume_square_a    = env_volume_in[0];
      out_in.volume_square_b    = env_volume_in[1];
      out_in.volume_noise       = env_volume_in[2];
      out_in.sequencer_position = seq_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         seq_ff       <= '0;
         on_ff        <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         seq_ff       <= seq_in;
         on_ff        <= on_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_ff <= req_data;
      end
      if (fire) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef NO_ASSERTIONS
   // a processed request always leaves a response behind
   a_fire_fills_result: assert property (@(posedge clock) disable iff (reset)
      fire |=> out_valid_ff)
      else $error("processed request produced no response");

   // the step counter moves by exactly one on a processed tick
   a_seq_advance: assert property (@(posedge clock) disable iff (reset)
      (fire && ctrl.tick_length == ~seq_ff[0] && psgfs_op_type'(in_ff.operation) == OP_TICK)
      |=> seq_ff == $past(seq_ff) + 3'd1)
      else $error("step counter did not advance on tick");

   // sweep overflow leaves channel 0 disabled
   a_overflow_disables: assert property (@(posedge clock) disable iff (reset)
      sweep_overflow |=> !on_ff[CH_SQUARE_A])
      else $error("channel 0 still enabled after sweep overflow");

   // backpressure only with a full input register and a blocked result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && out_valid_ff && rsp_stall))
      else $error("request stalled without cause");
`endif

endmodule

[design/psgfs_length.sv]
// length counters of the four channels
module psgfs_length
   import psgfs_pkg::*;
#(
   parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  psgfs_ctrl_type          ctrl,
   input  logic [1:0]              channel,
   input  logic                    enable_bit,
   input  logic [LEN_FIELD_W-1:0]  length_value,
   output logic [NUM_CHANNELS-1:0] expire
);

   logic                    counting_ff [NUM_CHANNELS];
   logic                    counting_in [NUM_CHANNELS];
   logic [LENGTH_WIDTH-1:0] count_ff    [NUM_CHANNELS];
   logic [LENGTH_WIDTH-1:0] count_in    [NUM_CHANNELS];

   logic [LENGTH_WIDTH+LEN_FIELD_W-1:0] load_wide;
   logic [LENGTH_WIDTH-1:0]             load_count;

   // zero-extend then cut, so both narrower and wider counters work
   assign load_wide  = {{LENGTH_WIDTH{1'b0}}, length_value};
   assign load_count = load_wide[LENGTH_WIDTH-1:0];

   always_comb begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         counting_in[c] = counting_ff[c];
         count_in[c]    = count_ff[c];
         expire[c]      = 1'b0;
         if (ctrl.tick_length && counting_ff[c]) begin
            if (count_ff[c] != '0) begin
               count_in[c] = count_ff[c] - 1'b1;
            end
            if (count_in[c] == '0) begin
               expire[c] = 1'b1;
            end
         end
      end
      if (ctrl.load_length) begin
         counting_in[channel] = enable_bit;
         count_in[channel]    = load_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            counting_ff[c] <= 1'b0;
            count_ff[c]    <= '0;
         end
      end else begin
         for (int c = 0; c < NUM_CHANNELS; c++) begin
            counting_ff[c] <= counting_in[c];
            count_ff[c]    <= count_in[c];
         end
      end
   end

endmodule

[design/psgfs_sweep.sv]
// frequency sweep unit of channel 0
module psgfs_sweep
   import psgfs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  psgfs_ctrl_type    ctrl,
   input  logic [FREQ_W-1:0] frequency,
   input  logic [2:0]        sweep_shift,
   input  logic [2:0]        sweep_period,
   input  logic              direction,
   output logic [FREQ_W-1:0] freq_in,
   output logic              overflow
);

   logic [FREQ_W-1:0] freq_ff;
   logic [FREQ_W-1:0] shadow_ff;
   logic [FREQ_W-1:0] shadow_in;
   logic [2:0]        shift_ff;
   logic [2:0]        shift_in;
   logic              subtract_ff;
   logic              subtract_in;
   logic [2:0]        period_ff;
   logic [2:0]        period_in;
   logic [2:0]        countdown_ff;
   logic [2:0]        countdown_in;
   logic              halted_ff;
   logic              halted_in;

   logic [FREQ_W-1:0] delta;
   logic [FREQ_W:0]   candidate;
   logic [2:0]        count_dec;

   assign delta     = shadow_ff >> shift_ff;
   // subtraction never goes below zero since delta <= shadow
   assign candidate = subtract_ff ? ({1'b0, shadow_ff} - {1'b0, delta})
                                  : ({1'b0, shadow_ff} + {1'b0, delta});
   assign count_dec = countdown_ff - 3'd1;

   always_comb begin
      freq_in      = freq_ff;
      shadow_in    = shadow_ff;
      shift_in     = shift_ff;
      subtract_in  = subtract_ff;
      period_in    = period_ff;
      countdown_in = countdown_ff;
      halted_in    = halted_ff;
      overflow     = 1'b0;
      if (ctrl.tick_sweep && period_ff != 3'd0 && !halted_ff) begin
         countdown_in = count_dec;
         if (count_dec == 3'd0) begin
            if (candidate[FREQ_W]) begin
               overflow  = 1'b1;
               halted_in = 1'b1;
            end else begin
               if (shift_ff != 3'd0) begin
                  freq_in   = candidate[FREQ_W-1:0];
                  shadow_in = candidate[FREQ_W-1:0];
               end
               countdown_in = period_ff;
            end
         end
      end
      if (ctrl.load_sweep) begin
         freq_in      = frequency;
         shadow_in    = frequency;
         shift_in     = sweep_shift;
         subtract_in  = direction;
         period_in    = sweep_period;
         countdown_in = sweep_period;
         halted_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff      <= '0;
         shadow_ff    <= '0;
         shift_ff     <= '0;
         subtract_ff  <= 1'b0;
         period_ff    <= '0;
         countdown_ff <= '0;
         halted_ff    <= 1'b0;
      end else begin
         freq_ff      <= freq_in;
         shadow_ff    <= shadow_in;
         shift_ff     <= shift_in;
         subtract_ff  <= subtract_in;
         period_ff    <= period_in;
         countdown_ff <= countdown_in;
         halted_ff    <= halted_in;
      end
   end

endmodule

[design/psgfs_envelope.sv]
// one volume envelope unit
module psgfs_envelope
   import psgfs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  logic             load,
   input  logic             direction,
   input  logic [2:0]       envelope_period,
   input  logic [VOL_W-1:0] start_volume,
   output logic [VOL_W-1:0] volume_in
);

   logic [2:0]       period_ff;
   logic [2:0]       period_in;
   logic             up_ff;
   logic             up_in;
   logic [2:0]       countdown_ff;
   logic [2:0]       countdown_in;
   logic [VOL_W-1:0] volume_ff;
   logic [2:0]       count_dec;

   assign count_dec = countdown_ff - 3'd1;

   always_comb begin
      period_in    = period_ff;
      up_in        = up_ff;
      countdown_in = countdown_ff;
      volume_in    = volume_ff;
      if (tick && period_ff != 3'd0) begin
         countdown_in = count_dec;
         if (count_dec == 3'd0) begin
            countdown_in = period_ff;
            if (up_ff) begin
               if (volume_ff != VOL_MAX) begin
                  volume_in = volume_ff + 1'b1;
               end
            end else if (volume_ff != '0) begin
               volume_in = volume_ff - 1'b1;
            end
         end
      end
      if (load) begin
         period_in    = envelope_period;
         up_in        = direction;
         countdown_in = envelope_period;
         volume_in    = start_volume;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff    <= '0;
         up_ff        <= 1'b0;
         countdown_ff <= '0;
         volume_ff    <= '0;
      end else begin
         period_ff    <= period_in;
         up_ff        <= up_in;
         countdown_ff <= countdown_in;
         volume_ff    <= volume_in;
      end
   end

endmodule

[bench/tb.sv]
// self-checking bench for the psg frame sequencer: random and directed requests, response check
`timescale 1ns / 1ps

module tb;
   import psgfs_pkg::*;

   // spare operation codes the block must pass through untouched
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam int LEN_W        = LENGTH_WIDTH_DEFAULT;
   localparam int RANDOM_COUNT = 500;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int DRAIN_CYCLES = 12;     // leave plenty of room for the last responses
   localparam int IDLE_PCT     = 14;
   localparam int QUIET_LO     = 300;    // window with no idling on either side
   localparam int QUIET_HI     = 400;
   localparam int HOLD_AT      = 120;    // start of the long response hold
   localparam int HOLD_CYCLES  = 80;

   logic          clock     = 1'b0;
   logic          reset     = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   psgfs_req_type req_data  = '0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   psgfs_rsp_type rsp_data;

   psg_frame_sequencer DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // requests waiting to be offered, and the status each accepted request should produce
   psgfs_req_type request_backlog [$];
   psgfs_rsp_type expected_status [$];

   int  error_count    = 0;
   int  cycle_count    = 0;
   int  accepted_count = 0;
   int  received_count = 0;
   int  tick_count     = 0;
   int  load_count     = 0;
   int  hold_left      = 0;
   bit  hold_done      = 1'b0;
   bit  saw_req_stall  = 1'b0;

   // shadow copy of the sequencer state, all zero out of reset
   logic [2:0]        seq_pos = '0;
   logic [3:0]        ch_on   = '0;
   logic [3:0]        len_on  = '0;
   logic [LEN_W-1:0]  len_count [NUM_CHANNELS] = '{default: '0};
   logic [FREQ_W-1:0] sw_freq   = '0;
   logic [FREQ_W-1:0] sw_shadow = '0;
   logic [2:0]        sw_shift  = '0;
   logic              sw_sub    = 1'b0;
   logic [2:0]        sw_period = '0;
   logic [2:0]        sw_count  = '0;
   logic              sw_halt   = 1'b0;
   logic [2:0]        env_per  [NUM_ENVELOPES] = '{default: '0};
   logic              env_rise [NUM_ENVELOPES] = '{default: 1'b0};
   logic [2:0]        env_cnt  [NUM_ENVELOPES] = '{default: '0};
   logic [VOL_W-1:0]  env_vol  [NUM_ENVELOPES] = '{default: '0};

   task automatic report_error(input string what);
      $display("ERROR @%0t: %s", $realtime, what);
      error_count++;
   endtask

   function automatic psgfs_req_type make_req(input logic [2:0] op, input logic [1:0] ch,
                                              input logic en, input int len, input int freq,
                                              input int shift, input int speriod,
                                              input logic dir, input int eperiod,
                                              input int vol);
      psgfs_req_type r;
      r.operation       = op;
      r.channel         = ch;
      r.enable_bit      = en;
      r.length_value    = LEN_FIELD_W'(len);
      r.frequency       = FREQ_W'(freq);
      r.sweep_shift     = 3'(shift);
      r.sweep_period    = 3'(speriod);
      r.direction       = dir;
      r.envelope_period = 3'(eperiod);
      r.start_volume    = VOL_W'(vol);
      return r;
   endfunction

   // applies one request to the shadow state and returns the status it leaves behind
   function automatic psgfs_rsp_type advance_frame(input psgfs_req_type r);
      psgfs_rsp_type     s;
      logic [FREQ_W-1:0] delta;
      logic [FREQ_W:0]   cand;
      case (r.operation)
         OP_TICK: begin
            // length counters on even steps, saturating at zero
            if (!seq_pos[0]) begin
               for (int c = 0; c < NUM_CHANNELS; c++) begin
                  if (len_on[c]) begin
                     if (len_count[c] != '0) len_count[c] = len_count[c] - 1'b1;
                     if (len_count[c] == '0) ch_on[c] = 1'b0;
                  end
               end
            end
            // frequency sweep on the two sweep steps
            if ((seq_pos == STEP_SWEEP_A || seq_pos == STEP_SWEEP_B) &&
                sw_period != '0 && !sw_halt) begin
               sw_count = sw_count - 1'b1;
               if (sw_count == '0) begin
                  delta = sw_shadow >> sw_shift;
                  cand  = sw_sub ? {1'b0, sw_shadow} - delta : {1'b0, sw_shadow} + delta;
                  if (cand[FREQ_W]) begin
                     // overflow kills the channel and freezes the sweep
                     ch_on[CH_SQUARE_A] = 1'b0;
                     sw_halt            = 1'b1;
                  end else begin
                     if (sw_shift != '0) begin
                        sw_freq   = cand[FREQ_W-1:0];
                        sw_shadow = cand[FREQ_W-1:0];
                     end
                     sw_count = sw_period;
                  end
               end
            end
            // volume envelopes on the last step, held at the rails
            if (seq_pos == STEP_ENV) begin
               for (int e = 0; e < NUM_ENVELOPES; e++) begin
                  if (env_per[e] != '0) begin
                     env_cnt[e] = env_cnt[e] - 1'b1;
                     if (env_cnt[e] == '0) begin
                        env_cnt[e] = env_per[e];
                        if (env_rise[e]) begin
                           if (env_vol[e] != VOL_MAX) env_vol[e] = env_vol[e] + 1'b1;
                        end else if (env_vol[e] != '0) begin
                           env_vol[e] = env_vol[e] - 1'b1;
                        end
                     end
                  end
               end
            end
            seq_pos = seq_pos + 1'b1;
         end
         OP_LENGTH_LOAD: begin
            len_on[r.channel]    = r.enable_bit;
            len_count[r.channel] = LEN_W'(r.length_value);
         end
         OP_SWEEP_LOAD: begin
            // one sweep unit, whatever channel the request names
            sw_freq   = r.frequency;
            sw_shadow = r.frequency;
            sw_shift  = r.sweep_shift;
            sw_sub    = r.direction;
            sw_period = r.sweep_period;
            sw_count  = r.sweep_period;
            sw_halt   = 1'b0;
         end
         OP_ENV_LOAD: begin
            // the wave channel has no envelope, so no unit matches it
            for (int e = 0; e < NUM_ENVELOPES; e++) begin
               if (ENV_CHANNEL[e] == r.channel) begin
                  env_per[e]  = r.envelope_period;
                  env_rise[e] = r.direction;
                  env_cnt[e]  = r.envelope_period;
                  env_vol[e]  = r.start_volume;
               end
            end
         end
         OP_ENABLE_WRITE: ch_on[r.channel] = r.enable_bit;
         default: ;
      endcase
      s.channel_enables    = ch_on;
      s.sweep_frequency    = sw_freq;
      s.volume_square_a    = env_vol[0];
      s.volume_square_b    = env_vol[1];
      s.volume_noise       = env_vol[2];
      s.sequencer_position = seq_pos;
      return s;
   endfunction

   // request driver: predicts on acceptance, holds a stalled request, idles at random
   always @(posedge clock) begin
      bit offer;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(advance_frame(req_data));
            accepted_count <= accepted_count + 1;
            if (req_data.operation == OP_TICK) tick_count++;
            else if (req_data.operation <= OP_ENABLE_WRITE) load_count++;
         end
         if (req_valid && req_stall) begin
            saw_req_stall = 1'b1;   // keep the same request on the bus
         end else begin
            offer = request_backlog.size() != 0 &&
                    ((accepted_count >= QUIET_LO && accepted_count < QUIET_HI) ||
                     $urandom_range(99) >= IDLE_PCT);
            if (offer) begin
               req_data  <= request_backlog.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long response hold, counted here so the input side backs up behind it
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && accepted_count >= HOLD_AT) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // response monitor: checks every accepted response against the oldest prediction
   always @(posedge clock) begin
      psgfs_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            received_count <= received_count + 1;
            if (expected_status.size() == 0) begin
               report_error($sformatf("response %h with nothing outstanding", rsp_data));
            end else begin
               want = expected_status.pop_front();
               if (rsp_data.channel_enables !== want.channel_enables)
                  report_error($sformatf("channel_enables got %h want %h",
                                         rsp_data.channel_enables, want.channel_enables));
               if (rsp_data.sweep_frequency !== want.sweep_frequency)
                  report_error($sformatf("sweep_frequency got %0d want %0d",
                                         rsp_data.sweep_frequency, want.sweep_frequency));
               if (rsp_data.volume_square_a !== want.volume_square_a)
                  report_error($sformatf("volume_square_a got %0d want %0d",
                                         rsp_data.volume_square_a, want.volume_square_a));
               if (rsp_data.volume_square_b !== want.volume_square_b)
                  report_error($sformatf("volume_square_b got %0d want %0d",
                                         rsp_data.volume_square_b, want.volume_square_b));
               if (rsp_data.volume_noise !== want.volume_noise)
                  report_error($sformatf("volume_noise got %0d want %0d",
                                         rsp_data.volume_noise, want.volume_noise));
               if (rsp_data.sequencer_position !== want.sequencer_position)
                  report_error($sformatf("sequencer_position got %0d want %0d",
                                         rsp_data.sequencer_position,
                                         want.sequencer_position));
            end
         end
         rsp_stall <= hold_left > 0 ||
                      (!(received_count >= QUIET_LO && received_count < QUIET_HI) &&
                       $urandom_range(99) < IDLE_PCT);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      psgfs_req_type r;
      int            pick;

      // directed: channel bring-up, every load, the special cases, a full step cycle
      request_backlog.push_back(make_req(OP_TICK, CH_SQUARE_A, 0, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_ENABLE_WRITE, CH_SQUARE_A, 1, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_ENABLE_WRITE, CH_SQUARE_B, 1, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_ENABLE_WRITE, CH_WAVE, 1, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_ENABLE_WRITE, CH_NOISE, 1, 0, 0, 0, 0, 0, 0, 0));
      // zero count with counting on: enable drops on the next even step
      request_backlog.push_back(make_req(OP_LENGTH_LOAD, CH_SQUARE_A, 1, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_LENGTH_LOAD, CH_SQUARE_B, 1, 256, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_LENGTH_LOAD, CH_WAVE, 1, 1, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_LENGTH_LOAD, CH_NOISE, 0, 511, 0, 0, 0, 0, 0, 0));
      // sweep load through a non-zero channel; max frequency overflows on first clock
      request_backlog.push_back(make_req(OP_SWEEP_LOAD, CH_NOISE, 0, 0, 2047, 0, 1, 0, 0, 0));
      // wave channel envelope load is dropped
      request_backlog.push_back(make_req(OP_ENV_LOAD, CH_WAVE, 0, 0, 0, 0, 0, 1, 3, 9));
      request_backlog.push_back(make_req(OP_ENV_LOAD, CH_SQUARE_A, 0, 0, 0, 0, 0, 1, 1, 15));
      request_backlog.push_back(make_req(OP_ENV_LOAD, CH_SQUARE_B, 0, 0, 0, 0, 0, 0, 1, 0));
      request_backlog.push_back(make_req(OP_ENV_LOAD, CH_NOISE, 0, 0, 0, 0, 0, 1, 7, 14));
      repeat (7) request_backlog.push_back(make_req(OP_TICK, CH_SQUARE_A, 0, 0, 0, 0, 0, 0, 0, 0));
      // spare codes change nothing
      request_backlog.push_back(make_req(OP_SPARE_LO, CH_NOISE, 1, 511, 2047, 7, 7, 1, 7, 15));
      request_backlog.push_back(make_req(OP_SPARE_LO + 3'd1, CH_WAVE, 1, 0, 0, 0, 0, 0, 0, 0));
      request_backlog.push_back(make_req(OP_SPARE_HI, CH_SQUARE_B, 0, 0, 0, 0, 0, 0, 0, 0));
      // subtracting sweep with the widest shift
      request_backlog.push_back(make_req(OP_SWEEP_LOAD, CH_SQUARE_A, 0, 0, 1024, 7, 7, 1, 0, 0));

      // random: ticks the most common pick so the units keep getting clocked, loads mixed in
      while (request_backlog.size() < RANDOM_COUNT) begin
         pick = $urandom_range(99);
         if (pick < 45)      r.operation = OP_TICK;
         else if (pick < 55) r.operation = OP_LENGTH_LOAD;
         else if (pick < 65) r.operation = OP_SWEEP_LOAD;
         else if (pick < 75) r.operation = OP_ENV_LOAD;
         else if (pick < 92) r.operation = OP_ENABLE_WRITE;
         else                r.operation = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
         r.channel         = 2'($urandom_range(3));
         // enable writes lean toward turning channels on so they can expire later
         r.enable_bit      = (r.operation == OP_ENABLE_WRITE) ? ($urandom_range(9) < 7)
                                                               : 1'($urandom_range(1));
         r.length_value    = LEN_FIELD_W'($urandom_range(1) ? $urandom_range(15)
                                                            : $urandom_range(256));
         r.frequency       = FREQ_W'($urandom_range(1) ? $urandom_range(2047)
                                                       : $urandom_range(255));
         r.sweep_shift     = 3'($urandom_range(7));
         r.sweep_period    = 3'($urandom_range(7));
         r.direction       = 1'($urandom_range(1));
         r.envelope_period = 3'($urandom_range(7));
         r.start_volume    = VOL_W'($urandom_range(15));
         request_backlog.push_back(r);
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // drain: everything offered, accepted and answered
      do @(negedge clock);
      while (request_backlog.size() != 0 || req_valid || expected_status.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (expected_status.size() != 0)
         report_error($sformatf("%0d responses never arrived", expected_status.size()));

      $display("ran %0d ticks and %0d unit loads or enable writes, %0d responses checked",
               tick_count, load_count, received_count);
      $display("long response hold %s the request side",
               saw_req_stall ? "backed up" : "did not back up");
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
